### rtl/sdspi_pkg.sv
`default_nettype none
package sdspi_pkg;

  localparam int BLOCK_BYTES      = 512;
  localparam int RESPONSE_POLLS   = 255;
  localparam int IDLE_CLOCK_BYTES = 20;

  localparam int BYTE_CNT_W = 10;
  localparam int POLL_CNT_W = 19;
  localparam int TICK_CNT_W = 22;
  localparam logic [TICK_CNT_W-1:0] TICK_MAX = '1;

  // request codes
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_BYTE  = 3'd3;
  localparam logic [2:0] REQ_WDATA = 3'd4;
  localparam logic [2:0] REQ_TICK  = 3'd5;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE  = 6'h00;
  localparam logic [5:0] CMD_SEND_OP  = 6'h01;
  localparam logic [5:0] CMD_IF_COND  = 6'h08;
  localparam logic [5:0] CMD_STATUS   = 6'h0D;
  localparam logic [5:0] CMD_RD_BLOCK = 6'h11;
  localparam logic [5:0] CMD_WR_BLOCK = 6'h18;

  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] CRC_CMD0       = 8'h95;
  localparam logic [7:0] CRC_CMD8       = 8'h87;
  localparam logic [7:0] DATA_TOKEN     = 8'hFE;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [7:0] R1_IDLE        = 8'h01;
  localparam logic [7:0] R1_READY       = 8'h00;
  localparam logic [4:0] DRESP_MASK     = 5'h1F;
  localparam logic [4:0] DRESP_ACCEPTED = 5'h05;

  // error codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_IDLE      = 4'd1;
  localparam logic [3:0] ERR_NO_READY     = 4'd2;
  localparam logic [3:0] ERR_READ_CMD     = 4'd3;
  localparam logic [3:0] ERR_START_TMO    = 4'd4;
  localparam logic [3:0] ERR_BAD_TOKEN    = 4'd5;
  localparam logic [3:0] ERR_WRITE_CMD    = 4'd6;
  localparam logic [3:0] ERR_DATA_REJECT  = 4'd7;
  localparam logic [3:0] ERR_PROGRAM_TMO  = 4'd8;
  localparam logic [3:0] ERR_STATUS       = 4'd9;

  // configuration register indexes
  localparam logic [2:0] CFG_HIGH_CAP     = 3'd0;
  localparam logic [2:0] CFG_CMD_BUSY     = 3'd1;
  localparam logic [2:0] CFG_WRITE_BUSY   = 3'd2;
  localparam logic [2:0] CFG_START_POLL   = 3'd3;
  localparam logic [2:0] CFG_IDLE_RETRY   = 3'd4;
  localparam logic [2:0] CFG_READY_RETRY  = 3'd5;

  typedef enum logic [14:0] {
    PH_IDLE   = 15'b000000000000001,
    PH_CLOCK  = 15'b000000000000010,
    PH_BUSY   = 15'b000000000000100,
    PH_SEND   = 15'b000000000001000,
    PH_RESP   = 15'b000000000010000,
    PH_START  = 15'b000000000100000,
    PH_READ   = 15'b000000001000000,
    PH_RCRC   = 15'b000000010000000,
    PH_WTOKEN = 15'b000000100000000,
    PH_WNEED  = 15'b000001000000000,
    PH_WDATA  = 15'b000010000000000,
    PH_WCRC   = 15'b000100000000000,
    PH_WRESP  = 15'b001000000000000,
    PH_WBUSY  = 15'b010000000000000,
    PH_STAT2  = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic                  high_capacity;
    logic [TICK_CNT_W-1:0] cmd_busy_limit;
    logic [15:0]           write_busy_limit;
    logic [POLL_CNT_W-1:0] start_poll_limit;
    logic [7:0]            idle_retries;
    logic [7:0]            ready_retries;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       wr_need;
    logic       done_res;
    logic       success;
    logic [3:0] err_code;
    logic       busy_res;
  } res_t;

endpackage
`default_nettype wire

### rtl/sdspi_seq.sv
`default_nettype none
module sdspi_seq
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] block_addr,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  wr_byte,
  input  wire cfg_t        cfg,
  output res_t             res
);

  phase_t                phase_r, phase_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]            retry_cnt_r, retry_cnt_nxt;
  logic [POLL_CNT_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [TICK_CNT_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [31:0]           cmd_addr_r, cmd_addr_nxt;
  logic [5:0]            cmd_index_r, cmd_index_nxt;

  logic        do_start;
  logic [5:0]  start_idx;
  logic [31:0] start_arg;
  logic        fin;
  logic        fin_ok;
  logic [3:0]  fin_err;
  logic [31:0] blk_arg;
  logic [7:0]  frame;

  assign blk_arg = cfg.high_capacity ? block_addr : {block_addr[22:0], 9'd0};

  // next command frame byte, selected by the byte about to go out
  always_comb begin
    frame = IDLE_BYTE;
    case (byte_cnt_nxt)
      10'd0: frame = CMD_START_BITS | {2'b00, cmd_index_r};
      10'd1: frame = cmd_addr_r[31:24];
      10'd2: frame = cmd_addr_r[23:16];
      10'd3: frame = cmd_addr_r[15:8];
      10'd4: frame = cmd_addr_r[7:0];
      default: begin
        if (cmd_index_r == CMD_GO_IDLE) frame = CRC_CMD0;
        else if (cmd_index_r == CMD_IF_COND) frame = CRC_CMD8;
        else frame = IDLE_BYTE;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    retry_cnt_nxt = retry_cnt_r;
    poll_cnt_nxt  = poll_cnt_r;
    tick_cnt_nxt  = tick_cnt_r;
    cmd_addr_nxt  = cmd_addr_r;
    cmd_index_nxt = cmd_index_r;
    res           = '0;
    do_start      = 1'b0;
    start_idx     = CMD_GO_IDLE;
    start_arg     = '0;
    fin           = 1'b0;
    fin_ok        = 1'b0;
    fin_err       = ERR_NONE;

    case (req_type)
      REQ_INIT: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt    = PH_CLOCK;
          byte_cnt_nxt = '0;
          res.tx_valid = 1'b1;
          res.tx_byte  = IDLE_BYTE;
        end
      end
      REQ_READ: begin
        if (phase_r == PH_IDLE) begin
          do_start  = 1'b1;
          start_idx = CMD_RD_BLOCK;
          start_arg = blk_arg;
        end
      end
      REQ_WRITE: begin
        if (phase_r == PH_IDLE) begin
          do_start  = 1'b1;
          start_idx = CMD_WR_BLOCK;
          start_arg = blk_arg;
        end
      end
      REQ_BYTE: begin
        unique case (phase_r)
          PH_CLOCK: begin
            if ({1'b0, byte_cnt_r} + 11'd1 >= 11'(IDLE_CLOCK_BYTES)) begin
              retry_cnt_nxt = '0;
              do_start      = 1'b1;
              start_idx     = CMD_GO_IDLE;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end
          end
          PH_BUSY: begin
            res.tx_valid = 1'b1;
            if (rx_byte == IDLE_BYTE || tick_cnt_r > cfg.cmd_busy_limit) begin
              phase_nxt    = PH_SEND;
              byte_cnt_nxt = '0;
              res.tx_byte  = frame;
            end else begin
              res.tx_byte = IDLE_BYTE;
            end
          end
          PH_SEND: begin
            res.tx_valid = 1'b1;
            if (byte_cnt_r >= 10'd5) begin
              phase_nxt    = PH_RESP;
              poll_cnt_nxt = '0;
              res.tx_byte  = IDLE_BYTE;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              res.tx_byte  = frame;
            end
          end
          PH_RESP: begin
            if (rx_byte[7] && poll_cnt_r < POLL_CNT_W'(RESPONSE_POLLS)) begin
              poll_cnt_nxt = poll_cnt_r + 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end else begin
              case (cmd_index_r)
                CMD_GO_IDLE: begin
                  if (rx_byte == R1_IDLE) begin
                    retry_cnt_nxt = '0;
                    do_start      = 1'b1;
                    start_idx     = CMD_SEND_OP;
                  end else if ({1'b0, retry_cnt_r} + 9'd1 >= {1'b0, cfg.idle_retries}) begin
                    fin     = 1'b1;
                    fin_err = ERR_NO_IDLE;
                  end else begin
                    retry_cnt_nxt = retry_cnt_r + 1'b1;
                    do_start      = 1'b1;
                    start_idx     = CMD_GO_IDLE;
                  end
                end
                CMD_SEND_OP: begin
                  if (rx_byte == R1_READY) begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                  end else if ({1'b0, retry_cnt_r} + 9'd1 >= {1'b0, cfg.ready_retries}) begin
                    fin     = 1'b1;
                    fin_err = ERR_NO_READY;
                  end else begin
                    retry_cnt_nxt = retry_cnt_r + 1'b1;
                    do_start      = 1'b1;
                    start_idx     = CMD_SEND_OP;
                  end
                end
                CMD_RD_BLOCK: begin
                  if (rx_byte != 8'h00) begin
                    fin     = 1'b1;
                    fin_err = ERR_READ_CMD;
                  end else begin
                    phase_nxt    = PH_START;
                    poll_cnt_nxt = '0;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = IDLE_BYTE;
                  end
                end
                CMD_WR_BLOCK: begin
                  if (rx_byte != 8'h00) begin
                    fin     = 1'b1;
                    fin_err = ERR_WRITE_CMD;
                  end else begin
                    phase_nxt    = PH_WTOKEN;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = DATA_TOKEN;
                  end
                end
                default: begin
                  if (rx_byte != 8'h00) begin
                    fin     = 1'b1;
                    fin_err = ERR_STATUS;
                  end else begin
                    phase_nxt    = PH_STAT2;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = IDLE_BYTE;
                  end
                end
              endcase
            end
          end
          PH_START: begin
            if (rx_byte == IDLE_BYTE) begin
              if ({1'b0, poll_cnt_r} + 20'd1 >= {1'b0, cfg.start_poll_limit}) begin
                fin     = 1'b1;
                fin_err = ERR_START_TMO;
              end else begin
                poll_cnt_nxt = poll_cnt_r + 1'b1;
                res.tx_valid = 1'b1;
                res.tx_byte  = IDLE_BYTE;
              end
            end else if (rx_byte != DATA_TOKEN) begin
              fin     = 1'b1;
              fin_err = ERR_BAD_TOKEN;
            end else begin
              phase_nxt    = PH_READ;
              byte_cnt_nxt = '0;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end
          end
          PH_READ: begin
            res.rd_valid = 1'b1;
            res.rd_byte  = rx_byte;
            res.tx_valid = 1'b1;
            res.tx_byte  = IDLE_BYTE;
            if ({1'b0, byte_cnt_r} + 11'd1 >= 11'(BLOCK_BYTES)) begin
              phase_nxt    = PH_RCRC;
              byte_cnt_nxt = '0;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
            end
          end
          PH_RCRC: begin
            if (byte_cnt_r >= 10'd1) begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end
          end
          PH_WTOKEN: begin
            byte_cnt_nxt = '0;
            phase_nxt    = PH_WNEED;
            res.wr_need  = 1'b1;
          end
          PH_WDATA: begin
            if ({1'b0, byte_cnt_r} + 11'd1 >= 11'(BLOCK_BYTES)) begin
              phase_nxt    = PH_WCRC;
              byte_cnt_nxt = '0;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              phase_nxt    = PH_WNEED;
              res.wr_need  = 1'b1;
            end
          end
          PH_WCRC: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = IDLE_BYTE;
            if (byte_cnt_r >= 10'd1) phase_nxt = PH_WRESP;
            else byte_cnt_nxt = byte_cnt_r + 1'b1;
          end
          PH_WRESP: begin
            if ((rx_byte[4:0] & DRESP_MASK) != DRESP_ACCEPTED) begin
              fin     = 1'b1;
              fin_err = ERR_DATA_REJECT;
            end else begin
              phase_nxt    = PH_WBUSY;
              tick_cnt_nxt = '0;
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end
          end
          PH_WBUSY: begin
            if (rx_byte == IDLE_BYTE) begin
              do_start  = 1'b1;
              start_idx = CMD_STATUS;
            end else if (tick_cnt_r > {6'd0, cfg.write_busy_limit}) begin
              fin     = 1'b1;
              fin_err = ERR_PROGRAM_TMO;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = IDLE_BYTE;
            end
          end
          PH_STAT2: begin
            fin = 1'b1;
            if (rx_byte != 8'h00) fin_err = ERR_STATUS;
            else fin_ok = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_WDATA: begin
        if (phase_r == PH_WNEED) begin
          phase_nxt    = PH_WDATA;
          res.tx_valid = 1'b1;
          res.tx_byte  = wr_byte;
        end
      end
      REQ_TICK: begin
        if (tick_cnt_r != TICK_MAX) tick_cnt_nxt = tick_cnt_r + 1'b1;
      end
      default: ;
    endcase

    // command launch: wait for not-busy first
    if (do_start) begin
      cmd_index_nxt = start_idx;
      cmd_addr_nxt  = start_arg;
      tick_cnt_nxt  = '0;
      phase_nxt     = PH_BUSY;
      res.tx_valid  = 1'b1;
      res.tx_byte   = IDLE_BYTE;
    end

    if (fin) begin
      phase_nxt    = PH_IDLE;
      res.done_res = 1'b1;
      res.success  = fin_ok;
      res.err_code = fin_err;
    end

    res.cs_active = (phase_nxt != PH_IDLE) && (phase_nxt != PH_CLOCK);
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= '0;
      retry_cnt_r <= '0;
      poll_cnt_r  <= '0;
      tick_cnt_r  <= '0;
      cmd_addr_r  <= '0;
      cmd_index_r <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      retry_cnt_r <= retry_cnt_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      cmd_addr_r  <= cmd_addr_nxt;
      cmd_index_r <= cmd_index_nxt;
    end
  end

  // data phases never outrun the block size
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ || phase_r == PH_WDATA || phase_r == PH_WNEED)
      |-> byte_cnt_r < BYTE_CNT_W'(BLOCK_BYTES))
    else $error("byte count past block size");

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEND |-> byte_cnt_r <= 10'd5)
    else $error("command frame overrun");

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RESP |-> poll_cnt_r <= POLL_CNT_W'(RESPONSE_POLLS))
    else $error("response poll overrun");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type == REQ_TICK) |=> $stable(phase_r))
    else $error("tick changed phase");

endmodule
`default_nettype wire

### rtl/sd_spi_block_controller_unit.sv
// an accepted input transaction's result is registered and appears on the out_ channel in the next cycle
// throughput: one transaction per cycle; the single result register drains while the
//   next transaction is taken, and in_stall follows out_stall only when it is full
// reset: synchronous active-low rst_n returns the sequencer to idle, clears all
//   counters and loads the configuration registers with their default values
`default_nettype none
module sd_spi_block_controller_unit
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_block_addr,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_wr_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_cs_active,
  output logic             out_rd_valid,
  output logic [7:0]       out_rd_byte,
  output logic             out_wr_need,
  output logic             out_done_res,
  output logic             out_success,
  output logic [3:0]       out_err_code,
  output logic             out_busy_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_data
);

  cfg_t cfg_r;
  res_t res;
  res_t out_r;
  logic out_valid_r;
  logic accept;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_capacity    <= 1'b0;
      cfg_r.cmd_busy_limit   <= 22'd3000000;
      cfg_r.write_busy_limit <= 16'd600;
      cfg_r.start_poll_limit <= 19'd300000;
      cfg_r.idle_retries     <= 8'd10;
      cfg_r.ready_retries    <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HIGH_CAP:    cfg_r.high_capacity    <= cfg_data[0];
        CFG_CMD_BUSY:    cfg_r.cmd_busy_limit   <= cfg_data;
        CFG_WRITE_BUSY:  cfg_r.write_busy_limit <= cfg_data[15:0];
        CFG_START_POLL:  cfg_r.start_poll_limit <= cfg_data[18:0];
        CFG_IDLE_RETRY:  cfg_r.idle_retries     <= cfg_data[7:0];
        CFG_READY_RETRY: cfg_r.ready_retries    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sdspi_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .block_addr (in_block_addr),
    .rx_byte    (in_rx_byte),
    .wr_byte    (in_wr_byte),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_valid  = out_r.tx_valid;
  assign out_tx_byte   = out_r.tx_byte;
  assign out_cs_active = out_r.cs_active;
  assign out_rd_valid  = out_r.rd_valid;
  assign out_rd_byte   = out_r.rd_byte;
  assign out_wr_need   = out_r.wr_need;
  assign out_done_res  = out_r.done_res;
  assign out_success   = out_r.success;
  assign out_err_code  = out_r.err_code;
  assign out_busy_res  = out_r.busy_res;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res) |-> !out_busy_res)
    else $error("finished transaction still busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rd_valid) |-> out_tx_valid)
    else $error("read data without next exchange");

  // exchanges with chip select off only clock idle bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tx_valid && !out_cs_active) |-> out_tx_byte == IDLE_BYTE)
    else $error("non-idle byte with chip select off");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

### tb/tb_sd_spi_block_controller_unit.sv
`default_nettype none
module tb_sd_spi_block_controller_unit;
  import sdspi_pkg::*;

  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;
  localparam int PASSES = 8;
  localparam int PASS_ITEMS = 210;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] blk;
    logic [7:0]  rx;
    logic [7:0]  wb;
  } sd_req_t;

  typedef struct packed {
    phase_t                ph;
    logic [BYTE_CNT_W-1:0] nbyte;
    logic [7:0]            ntry;
    logic [POLL_CNT_W-1:0] npoll;
    logic [TICK_CNT_W-1:0] nticks;
    logic [31:0]           arg;
    logic [5:0]            cmd;
  } card_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_block_addr = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [7:0]  in_wr_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_cs_active;
  logic        out_rd_valid;
  logic [7:0]  out_rd_byte;
  logic        out_wr_need;
  logic        out_done_res;
  logic        out_success;
  logic [3:0]  out_err_code;
  logic        out_busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  cfg_t        card_cfg;
  card_state_t dut_st;   // follows accepted transactions
  card_state_t gen_st;   // follows generated transactions
  sd_req_t     req_q[$];
  res_t        exp_q[$];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          n_fail = 0;
  int          quiet_cycles = 0;
  bit          deaf_card = 1'b0;

  sd_spi_block_controller_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_block_addr(in_block_addr),
    .in_rx_byte(in_rx_byte),
    .in_wr_byte(in_wr_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tx_valid(out_tx_valid),
    .out_tx_byte(out_tx_byte),
    .out_cs_active(out_cs_active),
    .out_rd_valid(out_rd_valid),
    .out_rd_byte(out_rd_byte),
    .out_wr_need(out_wr_need),
    .out_done_res(out_done_res),
    .out_success(out_success),
    .out_err_code(out_err_code),
    .out_busy_res(out_busy_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit chance(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic void send(inout res_t r, input logic [7:0] b);
    r.tx_valid = 1'b1;
    r.tx_byte = b;
  endfunction

  function automatic void close_req(inout card_state_t s, inout res_t r, input logic ok,
                                    input logic [3:0] err);
    s.ph = PH_IDLE;
    r.done_res = 1'b1;
    r.success = ok;
    r.err_code = err;
  endfunction

  function automatic void issue_cmd(inout card_state_t s, inout res_t r, input logic [5:0] idx,
                                    input logic [31:0] a);
    s.cmd = idx;
    s.arg = a;
    s.nticks = '0;
    s.ph = PH_BUSY;
    send(r, IDLE_BYTE);
  endfunction

  function automatic logic [7:0] frame_byte(input card_state_t s, input int k);
    if (k == 0) return CMD_START_BITS | {2'b00, s.cmd};
    if (k <= 4) return s.arg[8*(4-k) +: 8];
    if (s.cmd == CMD_GO_IDLE) return CRC_CMD0;
    if (s.cmd == CMD_IF_COND) return CRC_CMD8;
    return IDLE_BYTE;
  endfunction

  // one transaction into the sequencer, returns the result it produces
  function automatic res_t card_step(inout card_state_t s, input sd_req_t it);
    res_t        r;
    logic [31:0] addr;
    r = '0;
    addr = card_cfg.high_capacity ? it.blk : {it.blk[22:0], 9'd0};
    case (it.req)
      REQ_INIT: if (s.ph == PH_IDLE) begin
        s.ph = PH_CLOCK;
        s.nbyte = '0;
        send(r, IDLE_BYTE);
      end
      REQ_READ: if (s.ph == PH_IDLE) issue_cmd(s, r, CMD_RD_BLOCK, addr);
      REQ_WRITE: if (s.ph == PH_IDLE) issue_cmd(s, r, CMD_WR_BLOCK, addr);
      REQ_WDATA: if (s.ph == PH_WNEED) begin
        s.ph = PH_WDATA;
        send(r, it.wb);
      end
      REQ_TICK: if (s.nticks != TICK_MAX) s.nticks++;
      REQ_BYTE: begin
        case (s.ph)
          PH_CLOCK: begin
            if (s.nbyte + 1 >= IDLE_CLOCK_BYTES) begin
              s.ntry = '0;
              issue_cmd(s, r, CMD_GO_IDLE, '0);
            end else begin
              s.nbyte++;
              send(r, IDLE_BYTE);
            end
          end
          PH_BUSY: begin
            // a busy wait that runs out still sends the command
            if (it.rx == IDLE_BYTE || s.nticks > card_cfg.cmd_busy_limit) begin
              s.ph = PH_SEND;
              s.nbyte = '0;
              send(r, frame_byte(s, 0));
            end else send(r, IDLE_BYTE);
          end
          PH_SEND: begin
            if (s.nbyte >= 5) begin
              s.ph = PH_RESP;
              s.npoll = '0;
              send(r, IDLE_BYTE);
            end else begin
              s.nbyte++;
              send(r, frame_byte(s, s.nbyte));
            end
          end
          PH_RESP: begin
            if (it.rx[7] && s.npoll < RESPONSE_POLLS) begin
              s.npoll++;
              send(r, IDLE_BYTE);
            end else begin
              case (s.cmd)
                CMD_GO_IDLE: begin
                  if (it.rx == R1_IDLE) begin
                    s.ntry = '0;
                    issue_cmd(s, r, CMD_SEND_OP, '0);
                  end else if (s.ntry + 1 >= card_cfg.idle_retries) begin
                    close_req(s, r, 1'b0, ERR_NO_IDLE);
                  end else begin
                    s.ntry++;
                    issue_cmd(s, r, CMD_GO_IDLE, '0);
                  end
                end
                CMD_SEND_OP: begin
                  if (it.rx == R1_READY) close_req(s, r, 1'b1, ERR_NONE);
                  else if (s.ntry + 1 >= card_cfg.ready_retries) begin
                    close_req(s, r, 1'b0, ERR_NO_READY);
                  end else begin
                    s.ntry++;
                    issue_cmd(s, r, CMD_SEND_OP, '0);
                  end
                end
                CMD_RD_BLOCK: begin
                  if (it.rx != 8'h00) close_req(s, r, 1'b0, ERR_READ_CMD);
                  else begin
                    s.ph = PH_START;
                    s.npoll = '0;
                    send(r, IDLE_BYTE);
                  end
                end
                CMD_WR_BLOCK: begin
                  if (it.rx != 8'h00) close_req(s, r, 1'b0, ERR_WRITE_CMD);
                  else begin
                    s.ph = PH_WTOKEN;
                    send(r, DATA_TOKEN);
                  end
                end
                default: begin
                  if (it.rx != 8'h00) close_req(s, r, 1'b0, ERR_STATUS);
                  else begin
                    s.ph = PH_STAT2;
                    send(r, IDLE_BYTE);
                  end
                end
              endcase
            end
          end
          PH_START: begin
            if (it.rx == IDLE_BYTE) begin
              if (s.npoll + 1 >= card_cfg.start_poll_limit) close_req(s, r, 1'b0, ERR_START_TMO);
              else begin
                s.npoll++;
                send(r, IDLE_BYTE);
              end
            end else if (it.rx != DATA_TOKEN) close_req(s, r, 1'b0, ERR_BAD_TOKEN);
            else begin
              s.ph = PH_READ;
              s.nbyte = '0;
              send(r, IDLE_BYTE);
            end
          end
          PH_READ: begin
            r.rd_valid = 1'b1;
            r.rd_byte = it.rx;
            if (s.nbyte + 1 >= BLOCK_BYTES) begin
              s.ph = PH_RCRC;
              s.nbyte = '0;
            end else s.nbyte++;
            send(r, IDLE_BYTE);
          end
          PH_RCRC: begin
            if (s.nbyte >= 1) close_req(s, r, 1'b1, ERR_NONE);
            else begin
              s.nbyte++;
              send(r, IDLE_BYTE);
            end
          end
          PH_WTOKEN: begin
            s.nbyte = '0;
            s.ph = PH_WNEED;
            r.wr_need = 1'b1;
          end
          PH_WDATA: begin
            if (s.nbyte + 1 >= BLOCK_BYTES) begin
              s.ph = PH_WCRC;
              s.nbyte = '0;
              send(r, IDLE_BYTE);
            end else begin
              s.nbyte++;
              s.ph = PH_WNEED;
              r.wr_need = 1'b1;
            end
          end
          PH_WCRC: begin
            if (s.nbyte >= 1) s.ph = PH_WRESP;
            else s.nbyte++;
            send(r, IDLE_BYTE);
          end
          PH_WRESP: begin
            if (it.rx[4:0] != DRESP_ACCEPTED) close_req(s, r, 1'b0, ERR_DATA_REJECT);
            else begin
              s.ph = PH_WBUSY;
              s.nticks = '0;
              send(r, IDLE_BYTE);
            end
          end
          PH_WBUSY: begin
            if (it.rx == IDLE_BYTE) issue_cmd(s, r, CMD_STATUS, '0);
            else if (s.nticks > card_cfg.write_busy_limit) close_req(s, r, 1'b0, ERR_PROGRAM_TMO);
            else send(r, IDLE_BYTE);
          end
          PH_STAT2: begin
            if (it.rx != 8'h00) close_req(s, r, 1'b0, ERR_STATUS);
            else close_req(s, r, 1'b1, ERR_NONE);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.cs_active = (s.ph != PH_IDLE) && (s.ph != PH_CLOCK);
    r.busy_res = (s.ph != PH_IDLE);
    return r;
  endfunction

  // card answer steered so that most sequences get deep into the flow
  function automatic logic [7:0] next_rx();
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    case (gen_st.ph)
      PH_BUSY: return chance(75) ? IDLE_BYTE : (b & 8'hFE);
      PH_RESP: begin
        // now and then a card that never answers within the poll window
        if (gen_st.npoll == 0) deaf_card = chance(2);
        if (deaf_card || chance(15)) return b | 8'h80;
        case (gen_st.cmd)
          CMD_GO_IDLE: return chance(75) ? R1_IDLE : {1'b0, b[6:0]};
          CMD_SEND_OP: return chance(60) ? R1_READY : {1'b0, b[6:0]};
          default: return chance(85) ? 8'h00 : {1'b0, b[6:0]};
        endcase
      end
      PH_START: begin
        if (chance(50)) return IDLE_BYTE;
        return chance(85) ? DATA_TOKEN : b;
      end
      PH_WRESP: return chance(75) ? {b[7:5], DRESP_ACCEPTED} : b;
      PH_WBUSY: return chance(40) ? IDLE_BYTE : (chance(50) ? 8'h00 : b);
      PH_STAT2: return chance(85) ? 8'h00 : b;
      default: return b;
    endcase
  endfunction

  function automatic sd_req_t mk(input logic [2:0] req, input logic [31:0] blk,
                                 input logic [7:0] rx, input logic [7:0] wb);
    return {req, blk, rx, wb};
  endfunction

  task automatic push_req(input sd_req_t it);
    void'(card_step(gen_st, it));
    req_q.push_back(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [21:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HIGH_CAP: card_cfg.high_capacity = val[0];
      CFG_CMD_BUSY: card_cfg.cmd_busy_limit = val;
      CFG_WRITE_BUSY: card_cfg.write_busy_limit = val[15:0];
      CFG_START_POLL: card_cfg.start_poll_limit = val[POLL_CNT_W-1:0];
      CFG_IDLE_RETRY: card_cfg.idle_retries = val[7:0];
      CFG_READY_RETRY: card_cfg.ready_retries = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [21:0] hc, input logic [21:0] cmd_busy,
                              input logic [21:0] wr_busy, input logic [21:0] start_poll,
                              input logic [21:0] idle_try, input logic [21:0] ready_try);
    write_reg(CFG_HIGH_CAP, hc);
    write_reg(CFG_CMD_BUSY, cmd_busy);
    write_reg(CFG_WRITE_BUSY, wr_busy);
    write_reg(CFG_START_POLL, start_poll);
    write_reg(CFG_IDLE_RETRY, idle_try);
    write_reg(CFG_READY_RETRY, ready_try);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    sd_req_t taken;
    sd_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = {in_req_type, in_block_addr, in_rx_byte, in_wr_byte};
        exp_q.push_back(card_step(dut_st, taken));
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && !chance(gap_pct)) begin
          nxt = req_q.pop_front();
          {in_req_type, in_block_addr, in_rx_byte, in_wr_byte} <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          $error("result transaction with nothing expected");
          n_fail++;
        end else begin
          want = exp_q.pop_front();
          check_field("tx_valid", want.tx_valid, out_tx_valid);
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("cs_active", want.cs_active, out_cs_active);
          check_field("rd_valid", want.rd_valid, out_rd_valid);
          check_field("rd_byte", want.rd_byte, out_rd_byte);
          check_field("wr_need", want.wr_need, out_wr_need);
          check_field("done_res", want.done_res, out_done_res);
          check_field("success", want.success, out_success);
          check_field("err_code", want.err_code, out_err_code);
          check_field("busy_res", want.busy_res, out_busy_res);
        end
      end
      out_stall <= chance(stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sd_spi_block_controller_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    sd_req_t it;
    int      made;
    int      w;
    int      pass_i;
    card_cfg.high_capacity = 1'b0;
    card_cfg.cmd_busy_limit = 22'd3000000;
    card_cfg.write_busy_limit = 16'd600;
    card_cfg.start_poll_limit = 19'd300000;
    card_cfg.idle_retries = 8'd10;
    card_cfg.ready_retries = 8'd100;
    dut_st = '0;
    dut_st.ph = PH_IDLE;
    gen_st = dut_st;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (pass_i = 0; pass_i < PASSES; pass_i++) begin
      if (pass_i != 0) begin
        case (pass_i)
          1: program_regs(1, 0, 0, 0, 0, 0);
          2: program_regs(1, 22'h3FFFFF, 22'h00FFFF, 22'h07FFFF, 22'hFF, 22'hFF);
          5: program_regs(0, $urandom_range(40, 5), $urandom_range(30, 1),
                          $urandom_range(20, 2), $urandom_range(10, 2), $urandom_range(10, 2));
          default: program_regs($urandom_range(1, 0), $urandom_range(4, 0),
                                $urandom_range(6, 0), $urandom_range(6, 0),
                                $urandom_range(4, 0), $urandom_range(6, 0));
        endcase
      end
      @(negedge clk);
      case (pass_i % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 63; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 63; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase

      if (pass_i == 0) begin
        // stray events while idle
        push_req(mk(REQ_BYTE, '0, IDLE_BYTE, '0));
        push_req(mk(REQ_WDATA, '1, '0, '1));
        push_req(mk(REQ_RSVD6, '1, '1, '1));
        push_req(mk(REQ_RSVD7, '0, '0, '0));
        push_req(mk(REQ_TICK, '0, '0, '0));
        // top block number, address shifted past 32 bits
        push_req(mk(REQ_READ, '1, '0, '0));
        push_req(mk(REQ_INIT, '0, '0, '0));
        push_req(mk(REQ_WRITE, '0, '0, '0));
        push_req(mk(REQ_BYTE, '0, 8'h00, '0));
        push_req(mk(REQ_BYTE, '0, IDLE_BYTE, '0));
        for (w = 0; w < 6; w++) push_req(mk(REQ_BYTE, '0, 8'($urandom_range(255, 0)), '0));
        push_req(mk(REQ_WDATA, '0, '0, 8'h5A));
        push_req(mk(REQ_BYTE, '0, 8'h80, '0));
        push_req(mk(REQ_BYTE, '0, 8'h00, '0));
        push_req(mk(REQ_BYTE, '0, IDLE_BYTE, '0));
        push_req(mk(REQ_BYTE, '0, 8'h7E, '0));
        push_req(mk(REQ_WRITE, '0, '0, '0));
      end

      made = 0;
      while (made < PASS_ITEMS || gen_st.ph != PH_IDLE) begin
        it = {3'($urandom_range(7, 0)), 32'($urandom()), 8'($urandom_range(255, 0)),
              8'($urandom_range(255, 0))};
        if (gen_st.ph == PH_IDLE) begin
          if (chance(10)) begin
            it.req = 3'($urandom_range(7, 3));
          end else begin
            w = $urandom_range(99, 0);
            it.req = (w < 40) ? REQ_INIT : ((w < 70) ? REQ_READ : REQ_WRITE);
            if (chance(10)) it.blk = '0;
            else if (chance(10)) it.blk = '1;
            made++;
          end
        end else if (chance(10)) begin
          it.req = REQ_TICK;
          made++;
        end else if (chance(3)) begin
          w = $urandom_range(2, 0);
          if (w == 0) it.req = 3'($urandom_range(2, 0));
          else if (w == 1) it.req = chance(50) ? REQ_RSVD6 : REQ_RSVD7;
          else it.req = (gen_st.ph == PH_WNEED) ? REQ_BYTE : REQ_WDATA;
        end else begin
          if (gen_st.ph == PH_WNEED) begin
            it.req = REQ_WDATA;
          end else begin
            it.req = REQ_BYTE;
            it.rx = next_rx();
          end
          made++;
        end
        push_req(it);
      end

      do @(negedge clk); while (req_q.size() != 0 || in_valid || exp_q.size() != 0);
    end

    repeat (4) @(negedge clk);
    if (n_fail == 0) begin
      $display("sd_spi_block_controller_unit: match");
    end else begin
      $display("sd_spi_block_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/sdspi_pkg.sv
rtl/sdspi_seq.sv
rtl/sd_spi_block_controller_unit.sv
tb/tb_sd_spi_block_controller_unit.sv
